>>> design/swm_pkg.sv
// Shared types and constants for the sliding window maximum unit.
// No dependencies; imported by the cell and the top level.
`timescale 1ns / 1ps

package swm_pkg;

    localparam int DEF_MAX_WINDOW  = 64;
    localparam int DEF_SAMPLE_BITS = 32;
    localparam int CFG_BITS        = 7;

    // Broadcast control for one update of the cell chain.
    typedef struct packed {
        logic step;   // a sample transaction is taken this cycle
        logic shift;  // front entry leaves; every cell loads its right neighbor
        logic clear;  // restart: treat all held entries as empty
    } swm_ctrl_t;

endpackage

>>> design/swm_cell.sv
// One entry of the monotonic candidate queue, held as value, age and valid bit.
// Depends on swm_pkg for the broadcast control struct.
`timescale 1ns / 1ps

module swm_cell
    import swm_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int AGE_BITS    = $clog2(DEF_MAX_WINDOW + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  swm_ctrl_t              ctrl,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   left_keep,
    input  logic                   right_valid,
    input  logic [SAMPLE_BITS-1:0] right_value,
    input  logic [AGE_BITS-1:0]    right_age,
    output logic                   keep,
    output logic                   valid,
    output logic [SAMPLE_BITS-1:0] value,
    output logic [AGE_BITS-1:0]    age
);

    logic                   valid_reg, valid_next;
    logic [SAMPLE_BITS-1:0] value_reg, value_next;
    logic [AGE_BITS-1:0]    age_reg, age_next;
    logic                   src_valid;
    logic [SAMPLE_BITS-1:0] src_value;
    logic [AGE_BITS-1:0]    src_age;

    always_comb begin
        src_valid = ctrl.shift ? right_valid : valid_reg;
        src_value = ctrl.shift ? right_value : value_reg;
        src_age   = ctrl.shift ? right_age   : age_reg;
        // equal values survive; only a strictly larger sample evicts
        keep = src_valid && !ctrl.clear && !($signed(sample) > $signed(src_value));
    end

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        age_next   = age_reg;
        if (ctrl.step) begin
            if (keep) begin
                valid_next = 1'b1;
                value_next = src_value;
                age_next   = src_age + AGE_BITS'(1);
            end else if (left_keep) begin
                // first free slot takes the new sample
                valid_next = 1'b1;
                value_next = sample;
                age_next   = '0;
            end else begin
                valid_next = 1'b0;
                value_next = src_value;
                age_next   = src_age;
            end
        end else if (ctrl.shift) begin
            valid_next = src_valid;
            value_next = src_value;
            age_next   = src_age;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        value_reg <= value_next;
        age_reg   <= age_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign age   = age_reg;

endmodule

>>> design/swm_out_buf.sv
// Two-entry result buffer between the cell chain and the master stream port.
// No package dependencies.
`timescale 1ns / 1ps

module swm_out_buf #(
    parameter int DATA_BITS = 33
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  logic [DATA_BITS-1:0] push_data,
    output logic                 full,
    output logic                 out_valid,
    output logic [DATA_BITS-1:0] out_data,
    input  logic                 out_ready
);

    logic                 head_valid_reg, head_valid_next;
    logic                 tail_valid_reg, tail_valid_next;
    logic [DATA_BITS-1:0] head_data_reg, head_data_next;
    logic [DATA_BITS-1:0] tail_data_reg, tail_data_next;
    logic                 pop;

    assign pop = head_valid_reg && out_ready;

    always_comb begin
        head_valid_next = head_valid_reg;
        tail_valid_next = tail_valid_reg;
        head_data_next  = head_data_reg;
        tail_data_next  = tail_data_reg;
        if (!head_valid_reg || pop) begin
            if (tail_valid_reg) begin
                head_valid_next = 1'b1;
                head_data_next  = tail_data_reg;
                tail_valid_next = push;
                tail_data_next  = push_data;
            end else begin
                head_valid_next = push;
                head_data_next  = push_data;
                tail_valid_next = 1'b0;
            end
        end else if (push) begin
            tail_valid_next = 1'b1;
            tail_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            tail_valid_reg <= tail_valid_next;
        end
        head_data_reg <= head_data_next;
        tail_data_reg <= tail_data_next;
    end

    assign full      = tail_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_data_reg;

endmodule

>>> design/sliding_window_maximum_unit.sv
// Sliding window maximum unit: top level, cell chain plus two-entry result buffer.
// m_tvalid rises in the cycle after an input transaction that produces a result, when the buffer is empty.
// Throughput: one sample per cycle; input stalls while the result buffer is full, and
//   while stale entries past the front are shifted out after window_len is lowered.
// Reset (aresetn low, synchronous): queue emptied, sample count cleared, window_len
//   back to 1, result buffer emptied; no clearing pass. Uses swm_pkg, swm_cell, swm_out_buf.
`timescale 1ns / 1ps

module sliding_window_maximum_unit
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration: window_len
    input  logic                                cfg_we,
    input  logic [CFG_BITS-1:0]                 cfg_wdata,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // [SAMPLE_BITS-1:0] sample
    input  logic                                s_tuser,   // [0] restart
    input  logic                                s_tlast,   // last_in
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,   // [SAMPLE_BITS-1:0] window_max
    output logic                                m_tlast    // last_out
);

    localparam int DATA_BYTES_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    // ages and counts run up to MAX_WINDOW
    localparam int AW = $clog2(MAX_WINDOW + 1);
    localparam int CW = (AW > CFG_BITS) ? AW : CFG_BITS;
    localparam logic [CW-1:0] MAX_W = CW'(MAX_WINDOW);

    // ------------------------------------------------------------------
    // Effective window length, clamped to 1..MAX_WINDOW when written.
    // ------------------------------------------------------------------
    logic [AW-1:0] win_reg, win_next;
    logic [CW-1:0] cfg_ext;

    assign cfg_ext = CW'(cfg_wdata);

    always_comb begin
        win_next = win_reg;
        if (cfg_we) begin
            if (cfg_ext == '0) begin
                win_next = AW'(1);
            end else if (cfg_ext > MAX_W) begin
                win_next = AW'(MAX_W);
            end else begin
                win_next = AW'(cfg_ext);
            end
        end
    end

    // ------------------------------------------------------------------
    // Cell chain. Cell 0 is the queue front (oldest, largest candidate).
    // Each cell sees only its left neighbor's keep and its right
    // neighbor's contents; the comparison with the new sample happens
    // in every cell at once.
    // ------------------------------------------------------------------
    swm_ctrl_t              ctrl;
    logic [SAMPLE_BITS-1:0] sample;
    logic [MAX_WINDOW:0]    valid_vec;
    logic [MAX_WINDOW-1:0]  keep_vec;
    logic [SAMPLE_BITS-1:0] value_arr [MAX_WINDOW+1];
    logic [AW-1:0]          age_arr   [MAX_WINDOW+1];

    assign sample = s_tdata[SAMPLE_BITS-1:0];

    // virtual empty cell past the end of the chain
    assign valid_vec[MAX_WINDOW] = 1'b0;
    assign value_arr[MAX_WINDOW] = '0;
    assign age_arr[MAX_WINDOW]   = '0;

    genvar k;
    generate
        for (k = 0; k < MAX_WINDOW; k++) begin : g_cell
            logic left_keep;
            if (k == 0) begin : g_front
                assign left_keep = 1'b1;
            end else begin : g_rest
                assign left_keep = keep_vec[k-1];
            end
            swm_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .AGE_BITS    (AW)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .sample      (sample),
                .left_keep   (left_keep),
                .right_valid (valid_vec[k+1]),
                .right_value (value_arr[k+1]),
                .right_age   (age_arr[k+1]),
                .keep        (keep_vec[k]),
                .valid       (valid_vec[k]),
                .value       (value_arr[k]),
                .age         (age_arr[k])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Window expiry. An entry leaves once its age at the next sample
    // reaches the window. Normally only the front can expire; after the
    // window shrinks, extra expired entries are shifted out one a cycle
    // (trim) while a sample waits, before that transaction is taken.
    // Trimming only with a sample waiting keeps a later window raise
    // from losing entries that are still inside the new window.
    // ------------------------------------------------------------------
    logic front_expired;
    logic second_expired;
    logic trim;
    logic buf_full;
    logic accept;

    assign front_expired  = valid_vec[0] &&
        ((AW+1)'(age_arr[0]) + (AW+1)'(1) >= (AW+1)'(win_reg));
    assign second_expired = valid_vec[1] &&
        ((AW+1)'(age_arr[1]) + (AW+1)'(1) >= (AW+1)'(win_reg));
    assign trim     = second_expired && s_tvalid;
    assign s_tready = !trim && !buf_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        ctrl.step  = accept;
        ctrl.shift = trim || (accept && front_expired);
        ctrl.clear = accept && s_tuser;
    end

    // ------------------------------------------------------------------
    // Samples seen since restart, saturating at the window length.
    // ------------------------------------------------------------------
    logic [AW-1:0] seen_reg, seen_next;
    logic [AW-1:0] seen_base;
    logic [AW-1:0] seen_step;
    logic          emit;

    always_comb begin
        seen_base = s_tuser ? '0 : seen_reg;
        if (seen_base < win_reg) begin
            seen_step = seen_base + AW'(1);
        end else begin
            seen_step = win_reg;
        end
        seen_next = accept ? seen_step : seen_reg;
        emit      = accept && (seen_step >= win_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg  <= AW'(1);
            seen_reg <= '0;
        end else begin
            win_reg  <= win_next;
            seen_reg <= seen_next;
        end
    end

    // New front value: the surviving front source, else the sample itself.
    logic [SAMPLE_BITS-1:0] front_src;
    logic [SAMPLE_BITS-1:0] new_max;

    assign front_src = ctrl.shift ? value_arr[1] : value_arr[0];
    assign new_max   = keep_vec[0] ? front_src : sample;

    // ------------------------------------------------------------------
    // Result buffer: {last, window_max}
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS:0] buf_out;

    swm_out_buf #(
        .DATA_BITS (SAMPLE_BITS + 1)
    ) u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (emit),
        .push_data ({s_tlast, new_max}),
        .full      (buf_full),
        .out_valid (m_tvalid),
        .out_data  (buf_out),
        .out_ready (m_tready)
    );

    assign m_tdata = DATA_BYTES_BITS'(buf_out[SAMPLE_BITS-1:0]);
    assign m_tlast = buf_out[SAMPLE_BITS];

`ifndef SYNTHESIS
    // occupied cells always form a contiguous run from the front
    a_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_vec[MAX_WINDOW-1:1] & ~valid_vec[MAX_WINDOW-2:0]) == '0))
        else $error("cell chain has a gap");

    // the queue is never empty right after a sample is taken
    a_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> valid_vec[0])
        else $error("queue empty after sample");

    // after a result is produced, m_tvalid is high on the master side next cycle
    a_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_tvalid)
        else $error("result lost");
`endif

endmodule

>>> sim/sliding_window_maximum_unit_tb.sv
// Self-checking testbench for sliding_window_maximum_unit: directed and random sample
// streams under several window lengths and idle patterns, checked against a local predictor.
// Depends on swm_pkg and the design sources only.
`timescale 1ns / 1ps

module sliding_window_maximum_unit_tb;
    import swm_pkg::*;

    localparam int SW        = DEF_SAMPLE_BITS;
    localparam int MAX_WIN   = DEF_MAX_WINDOW;
    localparam int SETTLE    = 80;     // > worst stale-entry shift-out after lowering the window
    localparam int HOLD_LEN  = 300;    // long receiver hold-off, in cycles
    localparam int STALL_CAP = 5000;   // watchdog: cycles with no transaction on either side
    localparam int N_PHASES  = 10;
    localparam int PHASE_LEN = 160;

    typedef struct {
        logic [SW-1:0] sample;
        bit            restart;
        bit            last;
    } sample_txn_t;

    typedef struct {
        logic signed [SW-1:0] window_max;
        bit                   last;
    } max_result_t;

    // DUT connections; every input starts at a known value
    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CFG_BITS-1:0] cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [SW-1:0]       s_tdata   = '0;
    logic                s_tuser   = 1'b0;
    logic                s_tlast   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [SW-1:0]       m_tdata;
    logic                m_tlast;

    sliding_window_maximum_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // stimulus and expectation stores
    sample_txn_t sample_q[$];
    max_result_t window_max_q[$];

    // predictor state: non-increasing candidate deque, front = window maximum
    logic signed [SW-1:0] cand_val[$];
    bit [31:0]            cand_pos[$];
    bit [31:0]            pos_ctr   = '0;
    int unsigned          seen_cnt  = 0;
    bit [CFG_BITS-1:0]    win_cfg   = CFG_BITS'(1);   // register reset value

    int  fail_count    = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_requests = 0;
    int  holds_served  = 0;
    int  hold_left     = 0;
    int  quiet_cycles  = 0;
    bit  in_taken      = 1'b0;
    bit  ready_next;
    sample_txn_t drv_txn;
    max_result_t exp_res;

    // One accepted sample through the predictor; queues a result once the window is full.
    task automatic advance_window(input logic signed [SW-1:0] smp, input bit rst, input bit lst);
        bit [31:0]   w;
        max_result_t res;
        if (win_cfg == 0)
            w = 1;
        else if (win_cfg > MAX_WIN)
            w = MAX_WIN;
        else
            w = 32'(win_cfg);
        if (rst) begin
            cand_val.delete();
            cand_pos.delete();
            seen_cnt = 0;
            pos_ctr  = '0;
        end
        // ages are modulo 2^32
        while (cand_val.size() != 0 && bit'(32'(pos_ctr - cand_pos[0]) >= w)) begin
            cand_val.delete(0);
            cand_pos.delete(0);
        end
        // strictly smaller entries go; an equal older entry stays
        while (cand_val.size() != 0 && cand_val[$] < smp) begin
            cand_val.delete(cand_val.size() - 1);
            cand_pos.delete(cand_pos.size() - 1);
        end
        cand_val.insert(cand_val.size(), smp);
        cand_pos.insert(cand_pos.size(), pos_ctr);
        pos_ctr = pos_ctr + 1;
        if (seen_cnt < w)
            seen_cnt++;
        if (seen_cnt > w)
            seen_cnt = w;
        if (seen_cnt >= w) begin
            res.window_max = cand_val[0];
            res.last       = lst;
            window_max_q.insert(window_max_q.size(), res);
        end
    endtask

    task automatic queue_sample(input logic [SW-1:0] v, input bit rst, input bit lst);
        sample_txn_t t;
        t.sample  = v;
        t.restart = rst;
        t.last    = lst;
        sample_q.insert(sample_q.size(), t);
    endtask

    // One sequence: mostly restart at the head and last at the tail, with some broken ones.
    task automatic queue_sequence(input int w, input int style);
        int                   len;
        logic signed [SW-1:0] v;
        logic signed [SW-1:0] base;
        bit                   rst;
        bit                   lst;
        len  = $urandom_range(3 * w + 2, 1);
        base = $urandom();
        for (int i = 0; i < len; i++) begin
            case (style)
                0: v = $urandom();
                1: begin
                    v = $urandom_range(16);
                    v = v - 8;
                end
                2: v = base + i;
                3: v = base - i;
                default: begin
                    case ($urandom_range(4))
                        0: v = {1'b1, {(SW-1){1'b0}}};
                        1: v = {1'b0, {(SW-1){1'b1}}};
                        2: v = '0;
                        3: v = '1;
                        default: v = $urandom();
                    endcase
                end
            endcase
            rst = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
            lst = (i == len - 1) ? ($urandom_range(9) != 0) : ($urandom_range(29) == 0);
            queue_sample(v, rst, lst);
        end
    endtask

    // Wait until every sample is in and every result is out, then let the block settle.
    task automatic wait_idle();
        while (sample_q.size() != 0 || s_tvalid || window_max_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_window(input bit [CFG_BITS-1:0] v);
        wait_idle();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        win_cfg    = v;
    endtask

    // Driver: holds a transaction until accepted, then pulls the next or idles.
    always @(negedge aclk) begin
        if (aresetn && !(s_tvalid && !in_taken)) begin
            if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                drv_txn = sample_q[0];
                sample_q.delete(0);
                s_tvalid <= 1'b1;
                s_tdata  <= drv_txn.sample;
                s_tuser  <= drv_txn.restart;
                s_tlast  <= drv_txn.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off counted here on request.
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            ready_next = 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served++;
            hold_left  = HOLD_LEN;
            ready_next = 1'b0;
        end else begin
            ready_next = ($urandom_range(99) >= recv_stall_pct);
        end
        m_tready <= aresetn && ready_next;
    end

    // Monitor: predict on each input transaction, check each output transaction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_taken = 1'b0;
        end else begin
            in_taken = s_tvalid && s_tready;
            if (in_taken)
                advance_window(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready) begin
                if (window_max_q.size() == 0) begin
                    $error("unexpected result: window_max %0d last_out %0b",
                           $signed(m_tdata), m_tlast);
                    fail_count++;
                end else begin
                    exp_res = window_max_q[0];
                    window_max_q.delete(0);
                    if (m_tdata !== exp_res.window_max) begin
                        $error("window_max: expected %0d, got %0d",
                               exp_res.window_max, $signed(m_tdata));
                        fail_count++;
                    end
                    if (m_tlast !== exp_res.last) begin
                        $error("last_out: expected %0b, got %0b", exp_res.last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_CAP) begin
            $display("sliding_window_maximum_unit regression: fail");
            $finish;
        end
    end

    initial begin
        int cfg_v;
        int eff;
        int target;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: window 1 at reset, sample extremes
        queue_sample({1'b1, {(SW-1){1'b0}}}, 1'b0, 1'b0);
        queue_sample({1'b0, {(SW-1){1'b1}}}, 1'b0, 1'b1);

        // window 3: last mark before a full window, equal values, extremes, restart+last
        write_window(CFG_BITS'(3));
        queue_sample(32'd5, 1'b1, 1'b0);
        queue_sample(32'd5, 1'b0, 1'b1);
        queue_sample('1, 1'b0, 1'b0);
        queue_sample(-32'sd2, 1'b0, 1'b0);
        queue_sample({1'b0, {(SW-1){1'b1}}}, 1'b0, 1'b0);
        queue_sample({1'b1, {(SW-1){1'b0}}}, 1'b0, 1'b0);
        queue_sample('0, 1'b0, 1'b0);
        queue_sample('1, 1'b0, 1'b0);
        queue_sample({1'b1, {(SW-1){1'b0}}}, 1'b1, 1'b1);

        // zero length acts as 1; lowered mid-stream, no restart
        write_window(CFG_BITS'(0));
        queue_sample(32'd3, 1'b0, 1'b0);
        queue_sample(-32'sd7, 1'b0, 1'b1);

        // above the maximum saturates
        write_window(CFG_BITS'(127));
        queue_sample(32'd10, 1'b1, 1'b0);
        queue_sample(32'd10, 1'b0, 1'b0);
        queue_sample(32'd11, 1'b0, 1'b1);

        // lowered below samples already seen: result right away
        write_window(CFG_BITS'(2));
        queue_sample(32'd1, 1'b0, 1'b0);
        queue_sample(32'd2, 1'b0, 1'b1);

        // random phases, idle pattern rotating: none, sender, receiver, both
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: cfg_v = 1;
                1: cfg_v = 64;
                2: cfg_v = 127;
                3: cfg_v = 0;
                4: cfg_v = 2;
                5: cfg_v = 7;
                6: cfg_v = $urandom_range(127);
                7: cfg_v = 33;
                8: cfg_v = 16;
                default: cfg_v = 5;
            endcase
            write_window(cfg_v[CFG_BITS-1:0]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            eff    = (cfg_v == 0) ? 1 : (cfg_v > MAX_WIN) ? MAX_WIN : cfg_v;
            target = sample_q.size() + PHASE_LEN;
            while (sample_q.size() < target)
                queue_sequence(eff, $urandom_range(4));
            // back-pressure: receiver holds off while the sender keeps offering
            if (ph == 4)
                hold_requests++;
        end

        wait_idle();
        if (fail_count == 0 && window_max_q.size() == 0)
            $display("sliding_window_maximum_unit regression: pass");
        else
            $display("sliding_window_maximum_unit regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
design/swm_pkg.sv
design/swm_cell.sv
design/swm_out_buf.sv
design/sliding_window_maximum_unit.sv
sim/sliding_window_maximum_unit_tb.sv
